[sv/sensor_telegram_duplicate_filter_top_assert.svh]
// Assertion macros shared by the sensor telegram duplicate filter modules.
// Depends on nothing; included inside module bodies.
`ifndef SENSOR_TELEGRAM_DUPLICATE_FILTER_TOP_ASSERT_SVH
`define SENSOR_TELEGRAM_DUPLICATE_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define STDF_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define STDF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/stdf_pkg.sv]
// Shared types and constants of the sensor telegram duplicate filter.
// Used by the controller, the datapath and the top level; depends on nothing.
package stdf_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int SLOT_CAP  = 4;
  localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_W    = 3;
  localparam int ID_W      = 32;
  localparam int TIME_W    = 32;
  localparam int SYNC_W    = 64;
  localparam int PKT_W     = 8;
  localparam int GAP_W     = 16;
  localparam int MSB_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [SLOT_W-1:0] NO_SLOT = 3'd4;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SYNC     = 2'd1,
    OP_TELEGRAM = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNED_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEARNED_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEARNED_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEARNED_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MSB_LOW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MSB_HIGH  = 3'd6;

  typedef struct packed {
    logic capture;
    logic eval;
    logic check;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic out_free;
  } status_t;

endpackage

[sv/stdf_ctrl.sv]
// Controller state machine of the sensor telegram duplicate filter.
// Depends on stdf_pkg and the assertion macro header.
module stdf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  stdf_pkg::status_t status,
  output stdf_pkg::cmd_t    cmd
);
  import stdf_pkg::*;
  `include "sensor_telegram_duplicate_filter_top_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_CHECK = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.eval    = 1'b0;
    cmd.check   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (status.op == OP_TELEGRAM) begin
          state_next = S_CHECK;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        if (status.out_free) begin
          cmd.check  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `STDF_ASSERT_NEXT(a_accept_to_eval, clk, rst, in_valid && in_ready, state == S_EVAL, "accepted beat did not reach evaluation")
  `STDF_ASSERT_NEXT(a_event_returns_idle, clk, rst, state == S_EVAL && status.op != OP_TELEGRAM, state == S_IDLE, "tick or sync did not return to idle")
  `STDF_ASSERT_IMP(a_check_needs_room, clk, rst, cmd.check, status.out_free, "result loaded while output register is full")

endmodule

[sv/stdf_dp.sv]
// Datapath of the sensor telegram duplicate filter: configuration, time base,
// slot table and output register. Depends on stdf_pkg and the assertion header.
module stdf_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  stdf_pkg::cmd_t                      cmd,
  output stdf_pkg::status_t                   status,
  input  logic                                cfg_valid,
  input  logic [stdf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stdf_pkg::CFG_W-1:0]          cfg_data,
  input  logic [1:0]                          op,
  input  logic [stdf_pkg::SYNC_W-1:0]         sync_time,
  input  logic [stdf_pkg::ID_W-1:0]           sensor_id,
  input  logic [stdf_pkg::PKT_W-1:0]          packet_id,
  input  logic                                developer_mode,
  input  logic                                autolearn_done,
  input  logic                                standstill_active,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                accepted,
  output logic                                route,
  output logic [stdf_pkg::TIME_W-1:0]         rx_time,
  output logic [stdf_pkg::SLOT_W-1:0]         matched_slot
);
  import stdf_pkg::*;
  `include "sensor_telegram_duplicate_filter_top_assert.svh"

  logic [ID_W-1:0]   learned_id [SLOT_CAP];
  logic [GAP_W-1:0]  min_gap_ms;
  logic [MSB_W-1:0]  id_msb_lowest;
  logic [MSB_W-1:0]  id_msb_highest;

  logic [TIME_W-1:0] slot_last_time [NUM_SLOTS];
  logic [PKT_W-1:0]  slot_last_packet [NUM_SLOTS];
  logic [TIME_W-1:0] local_time;
  logic [SYNC_W-1:0] sync_start;
  logic              sync_started;

  op_t               op_r;
  logic [SYNC_W-1:0] sync_time_r;
  logic [ID_W-1:0]   sensor_id_r;
  logic [PKT_W-1:0]  packet_id_r;
  logic              dev_r;
  logic              learned_r;
  logic              stand_r;

  logic              in_range;
  logic              filter_on;
  logic              hit;
  logic [SLOT_AW-1:0] slot;

  logic              hit_next;
  logic [SLOT_AW-1:0] slot_next;
  logic              range_next;
  logic [SYNC_W-1:0] sync_diff;
  logic [TIME_W-1:0] limit;
  logic              newer;
  logic              pass_slot;
  logic              accept_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_CAP; i++) begin
        learned_id[i] <= '0;
      end
      min_gap_ms     <= '0;
      id_msb_lowest  <= '0;
      id_msb_highest <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEARNED_0: learned_id[0]  <= cfg_data;
        REG_LEARNED_1: learned_id[1]  <= cfg_data;
        REG_LEARNED_2: learned_id[2]  <= cfg_data;
        REG_LEARNED_3: learned_id[3]  <= cfg_data;
        REG_MIN_GAP:   min_gap_ms     <= cfg_data[GAP_W-1:0];
        REG_MSB_LOW:   id_msb_lowest  <= cfg_data[MSB_W-1:0];
        REG_MSB_HIGH:  id_msb_highest <= cfg_data[MSB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= op_t'(op);
      sync_time_r <= sync_time;
      sensor_id_r <= sensor_id;
      packet_id_r <= packet_id;
      dev_r       <= developer_mode;
      learned_r   <= autolearn_done;
      stand_r     <= standstill_active;
    end
  end

  always_comb begin
    hit_next  = 1'b0;
    slot_next = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (learned_id[i] == sensor_id_r) begin
        hit_next  = 1'b1;
        slot_next = SLOT_AW'(i);
      end
    end
    range_next = (sensor_id_r[ID_W-1 -: MSB_W] >= id_msb_lowest) &&
                 (sensor_id_r[ID_W-1 -: MSB_W] <= id_msb_highest);
    sync_diff  = sync_time_r - sync_start;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      in_range  <= range_next;
      filter_on <= !dev_r && learned_r;
      hit       <= hit_next;
      slot      <= slot_next;
    end
  end

  always_comb begin
    limit       = slot_last_time[slot] + TIME_W'(min_gap_ms);
    newer       = (local_time > limit) || (packet_id_r != slot_last_packet[slot]);
    pass_slot   = in_range && filter_on && hit && newer;
    accept_next = in_range && (!filter_on || (hit && newer));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_time   <= '0;
      sync_start   <= '0;
      sync_started <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_last_time[i]   <= '0;
        slot_last_packet[i] <= '1;
      end
    end else begin
      if (cmd.eval && op_r == OP_TICK) begin
        local_time <= local_time + TIME_W'(1);
      end else if (cmd.eval && op_r == OP_SYNC) begin
        if (!sync_started) begin
          sync_start   <= sync_time_r;
          sync_started <= 1'b1;
          local_time   <= '0;
        end else if (sync_time_r > sync_start) begin
          local_time <= sync_diff[TIME_W-1:0];
        end
      end
      if (cmd.check && pass_slot) begin
        slot_last_time[slot]   <= local_time;
        slot_last_packet[slot] <= packet_id_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.check) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      accepted     <= accept_next;
      route        <= accept_next && stand_r;
      rx_time      <= local_time;
      matched_slot <= (in_range && filter_on && hit) ? SLOT_W'(slot) : NO_SLOT;
    end
  end

  assign status.op       = op_r;
  assign status.out_free = !out_valid || out_ready;

  `STDF_ASSERT_IMP(a_route_needs_accept, clk, rst, out_valid && !accepted, !route, "route set on a rejected telegram")
  `STDF_ASSERT_IMP(a_slot_in_range, clk, rst, out_valid, matched_slot <= NO_SLOT, "matched slot beyond the slot count")
  `STDF_ASSERT_NEXT(a_tick_counts, clk, rst, cmd.eval && op_r == OP_TICK, local_time == TIME_W'($past(local_time) + TIME_W'(1)), "tick did not advance local time")

endmodule

[sv/sensor_telegram_duplicate_filter_top.sv]
// A telegram passes capture, evaluation and slot check; no other beat is taken meanwhile.
// Ticks and syncs pass through capture, then evaluation, before the next beat is taken.
// A telegram holds in its slot check, and the input stays off, while an earlier result waits.
// Reset is synchronous: configuration returns to defaults, local time and sync state
// clear, slot times clear and slot packet IDs go to all ones.
module sensor_telegram_duplicate_filter_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [stdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stdf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     op,
  input  logic [stdf_pkg::SYNC_W-1:0]    sync_time,
  input  logic [stdf_pkg::ID_W-1:0]      sensor_id,
  input  logic [stdf_pkg::PKT_W-1:0]     packet_id,
  input  logic                           developer_mode,
  input  logic                           autolearn_done,
  input  logic                           standstill_active,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           accepted,
  output logic                           route,
  output logic [stdf_pkg::TIME_W-1:0]    rx_time,
  output logic [stdf_pkg::SLOT_W-1:0]    matched_slot
);
  import stdf_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  stdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  stdf_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .op                (op),
    .sync_time         (sync_time),
    .sensor_id         (sensor_id),
    .packet_id         (packet_id),
    .developer_mode    (developer_mode),
    .autolearn_done    (autolearn_done),
    .standstill_active (standstill_active),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .accepted          (accepted),
    .route             (route),
    .rx_time           (rx_time),
    .matched_slot      (matched_slot)
  );

endmodule

[verif/telegram_filter_checker.sv]
// Checker for the sensor telegram duplicate filter: follows the register, event and
// result channels, predicts each telegram verdict and compares every result beat.
// Depends on stdf_pkg for widths, register indexes and event codes.
module telegram_filter_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [stdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stdf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     op,
  input  logic [stdf_pkg::SYNC_W-1:0]    sync_time,
  input  logic [stdf_pkg::ID_W-1:0]      sensor_id,
  input  logic [stdf_pkg::PKT_W-1:0]     packet_id,
  input  logic                           developer_mode,
  input  logic                           autolearn_done,
  input  logic                           standstill_active,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           accepted,
  input  logic                           route,
  input  logic [stdf_pkg::TIME_W-1:0]    rx_time,
  input  logic [stdf_pkg::SLOT_W-1:0]    matched_slot,
  output int                             fail_count,
  output int                             pending,
  output int                             results_seen,
  output int                             passed_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import stdf_pkg::*;

  typedef struct packed {
    logic              accepted;
    logic              route;
    logic [TIME_W-1:0] rx_time;
    logic [SLOT_W-1:0] matched_slot;
  } verdict_t;

  logic [ID_W-1:0]   learned_id [SLOT_CAP];
  logic [GAP_W-1:0]  min_gap;
  logic [MSB_W-1:0]  msb_lowest;
  logic [MSB_W-1:0]  msb_highest;
  logic [TIME_W-1:0] slot_time [SLOT_CAP];
  logic [PKT_W-1:0]  slot_packet [SLOT_CAP];
  logic [TIME_W-1:0] local_time;
  logic [SYNC_W-1:0] sync_start;
  logic              sync_started;
  verdict_t          verdict_q [$];
  int                fails = 0;
  int                results = 0;
  int                passes = 0;

  task automatic clear_state();
    for (int i = 0; i < SLOT_CAP; i++) begin
      learned_id[i]  = '0;
      slot_time[i]   = '0;
      slot_packet[i] = '1;
    end
    min_gap      = '0;
    msb_lowest   = '0;
    msb_highest  = '1;
    local_time   = '0;
    sync_start   = '0;
    sync_started = 1'b0;
    verdict_q.delete();
  endtask

  task automatic write_register();
    case (cfg_index)
      REG_LEARNED_0, REG_LEARNED_1, REG_LEARNED_2, REG_LEARNED_3: begin
        learned_id[cfg_index - REG_LEARNED_0] = cfg_data[ID_W-1:0];
      end
      REG_MIN_GAP:  min_gap     = cfg_data[GAP_W-1:0];
      REG_MSB_LOW:  msb_lowest  = cfg_data[MSB_W-1:0];
      REG_MSB_HIGH: msb_highest = cfg_data[MSB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic screen_event();
    logic [MSB_W-1:0]  msb;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] limit;
    logic              pass;
    verdict_t          v;
    int                i;
    msb  = sensor_id[ID_W-1 -: MSB_W];
    slot = NO_SLOT;
    pass = 1'b0;
    case (op_t'(op))
      OP_TICK: local_time = local_time + 1'b1;
      OP_SYNC: begin
        if (!sync_started) begin
          sync_start   = sync_time;
          sync_started = 1'b1;
          local_time   = '0;
        end else if (sync_time > sync_start) begin
          local_time = TIME_W'(sync_time - sync_start);
        end
      end
      OP_TELEGRAM: begin
        if (msb >= msb_lowest && msb <= msb_highest) begin
          if (!developer_mode && autolearn_done) begin
            // Scanning downward leaves the lowest matching slot.
            for (i = NUM_SLOTS - 1; i >= 0; i--) begin
              if (learned_id[i] == sensor_id) slot = SLOT_W'(i);
            end
            if (slot != NO_SLOT) begin
              limit = slot_time[slot] + TIME_W'(min_gap);
              if (local_time > limit || packet_id != slot_packet[slot]) begin
                pass              = 1'b1;
                slot_time[slot]   = local_time;
                slot_packet[slot] = packet_id;
              end
            end
          end else begin
            pass = 1'b1;
          end
        end
        v.accepted     = pass;
        v.route        = pass & standstill_active;
        v.rx_time      = local_time;
        v.matched_slot = slot;
        verdict_q.push_back(v);
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    verdict_t v;
    if (verdict_q.size() == 0) begin
      $error("result beat with no telegram outstanding: accepted=%0d rx_time=%0h",
             accepted, rx_time);
      fails++;
    end else begin
      v = verdict_q.pop_front();
      if (accepted !== v.accepted) begin
        $error("accepted: expected %0d, actual %0d", v.accepted, accepted);
        fails++;
      end
      if (route !== v.route) begin
        $error("route: expected %0d, actual %0d", v.route, route);
        fails++;
      end
      if (rx_time !== v.rx_time) begin
        $error("rx_time: expected %0h, actual %0h", v.rx_time, rx_time);
        fails++;
      end
      if (matched_slot !== v.matched_slot) begin
        $error("matched_slot: expected %0d, actual %0d", v.matched_slot, matched_slot);
        fails++;
      end
      if (v.accepted) passes++;
    end
    results++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (cfg_valid && cfg_ready) write_register();
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) screen_event();
    end
    fail_count   <= fails;
    pending      <= verdict_q.size();
    results_seen <= results;
    passed_count <= passes;
  end

endmodule

[verif/testbench.sv]
// Top of the sensor telegram duplicate filter testbench: clock, reset, register
// writes, event and result handshakes, watchdog and verdict.
// Depends on stdf_pkg, sensor_telegram_duplicate_filter_top and telegram_filter_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import stdf_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 250;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;

  typedef struct packed {
    logic [1:0]        op;
    logic [SYNC_W-1:0] sync_time;
    logic [ID_W-1:0]   sensor_id;
    logic [PKT_W-1:0]  packet_id;
    logic              dev;
    logic              learned;
    logic              standstill;
  } event_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           op = OP_TICK;
  logic [SYNC_W-1:0]    sync_time = '0;
  logic [ID_W-1:0]      sensor_id = '0;
  logic [PKT_W-1:0]     packet_id = '0;
  logic                 developer_mode = 1'b0;
  logic                 autolearn_done = 1'b0;
  logic                 standstill_active = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 accepted;
  logic                 route;
  logic [TIME_W-1:0]    rx_time;
  logic [SLOT_W-1:0]    matched_slot;
  int                   fail_count;
  int                   pending;
  int                   results_seen;
  int                   passed_count;

  logic [ID_W-1:0]      cfg_ids [SLOT_CAP];
  logic [GAP_W-1:0]     cfg_gap;
  logic [MSB_W-1:0]     cfg_lo;
  logic [MSB_W-1:0]     cfg_hi;
  logic [PKT_W-1:0]     last_pkt [SLOT_CAP];
  logic [SYNC_W-1:0]    base_time;
  logic [TIME_W-1:0]    time_guess = '0;
  logic                 synced = 1'b0;
  bit                   idle_on = 1'b1;
  int                   beats_sent = 0;
  int                   telegrams_sent = 0;
  int                   settings_used = 0;

  sensor_telegram_duplicate_filter_top dut (.*);

  telegram_filter_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic program_regs();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      write_reg(REG_LEARNED_0 + CFG_IDX_W'(i), cfg_ids[i]);
    end
    write_reg(REG_MIN_GAP, {16'($urandom), cfg_gap});
    write_reg(REG_MSB_LOW, {24'($urandom), cfg_lo});
    write_reg(REG_MSB_HIGH, {24'($urandom), cfg_hi});
    for (int i = 0; i < SLOT_CAP; i++) last_pkt[i] = '1;
    settings_used++;
  endtask

  task automatic quiesce();
    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_event(input event_t ev);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    op                <= ev.op;
    sync_time         <= ev.sync_time;
    sensor_id         <= ev.sensor_id;
    packet_id         <= ev.packet_id;
    developer_mode    <= ev.dev;
    autolearn_done    <= ev.learned;
    standstill_active <= ev.standstill;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (ev.op == OP_TICK) begin
      time_guess++;
    end else if (ev.op == OP_SYNC) begin
      if (!synced) begin
        synced     = 1'b1;
        base_time  = ev.sync_time;
        time_guess = '0;
      end else if (ev.sync_time > base_time) begin
        time_guess = TIME_W'(ev.sync_time - base_time);
      end
    end else if (ev.op == OP_TELEGRAM) begin
      telegrams_sent++;
    end
  endtask

  function automatic event_t make_event(input logic [1:0] kind, input logic [SYNC_W-1:0] t,
                                        input logic [ID_W-1:0] id, input logic [PKT_W-1:0] pkt,
                                        input logic dev, input logic learned,
                                        input logic standstill);
    event_t ev;
    ev.op         = kind;
    ev.sync_time  = t;
    ev.sensor_id  = id;
    ev.packet_id  = pkt;
    ev.dev        = dev;
    ev.learned    = learned;
    ev.standstill = standstill;
    return ev;
  endfunction

  function automatic event_t next_event();
    event_t ev;
    int     pick;
    int     s;
    pick          = $urandom_range(0, 99);
    s             = $urandom_range(0, NUM_SLOTS - 1);
    ev.sync_time  = {$urandom, $urandom};
    ev.sensor_id  = $urandom;
    ev.packet_id  = PKT_W'($urandom);
    ev.dev        = ($urandom_range(0, 9) == 0);
    ev.learned    = ($urandom_range(0, 7) != 0);
    ev.standstill = 1'($urandom_range(0, 1));
    if (pick < 30) begin
      ev.op = OP_TICK;
    end else if (pick < 38) begin
      ev.op = OP_SYNC;
      pick  = $urandom_range(0, 9);
      if (pick < 7) begin
        ev.sync_time = base_time + time_guess + $urandom_range(0, 2 * cfg_gap + 8);
      end else if (pick == 7) begin
        ev.sync_time = base_time - $urandom_range(0, 1000);
      end
    end else if (pick < 95) begin
      ev.op = OP_TELEGRAM;
      pick  = $urandom_range(0, 99);
      if (pick < 70) begin
        ev.sensor_id = cfg_ids[s];
        if ($urandom_range(0, 9) < 6) ev.packet_id = last_pkt[s];
        last_pkt[s] = ev.packet_id;
      end else if (pick < 85 && cfg_lo <= cfg_hi) begin
        ev.sensor_id[ID_W-1 -: MSB_W] = MSB_W'($urandom_range(cfg_lo, cfg_hi));
      end
    end else begin
      ev.op = OP_NONE;
    end
    return ev;
  endfunction

  task automatic choose_settings(input int phase);
    for (int i = 0; i < SLOT_CAP; i++) cfg_ids[i] = $urandom;
    cfg_gap = GAP_W'($urandom_range(0, 40));
    cfg_lo  = MSB_W'($urandom_range(0, 128));
    cfg_hi  = MSB_W'($urandom_range(128, 255));
    case (phase)
      0: begin
        cfg_gap = '0;
        cfg_lo  = '0;
        cfg_hi  = '1;
      end
      1: begin
        cfg_gap = '1;
        cfg_lo  = '0;
        cfg_hi  = '1;
      end
      2: begin
        cfg_lo = 8'hC8;
        cfg_hi = 8'h64;
      end
      3: begin
        cfg_lo = MSB_W'($urandom_range(0, 255));
        cfg_hi = cfg_lo;
      end
      4: begin
        cfg_ids[2] = cfg_ids[1];
        cfg_ids[3] = cfg_ids[0];
      end
      5: begin
        cfg_ids[0] = '0;
        cfg_ids[1] = '1;
        cfg_lo     = '0;
        cfg_hi     = '1;
      end
      default: ;
    endcase
    if (phase != 2 && phase != 5) begin
      for (int i = 0; i < SLOT_CAP; i++) begin
        cfg_ids[i][ID_W-1 -: MSB_W] = MSB_W'($urandom_range(cfg_lo, cfg_hi));
      end
    end
  endtask

  initial begin : receiver
    int  n;
    bit  held;
    held = 1'b0;
    wait (!rst);
    forever begin
      if (!held && beats_sent >= 400) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk) out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) @(negedge clk) out_ready <= 1'b0;
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) @(negedge clk) out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pending);
    $display("[sensor_telegram_duplicate_filter_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [SYNC_W-1:0] t0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    cfg_ids[0] = 32'h1234_5678;
    cfg_ids[1] = 32'h1234_5678;
    cfg_ids[2] = 32'hFFFF_FFFF;
    cfg_ids[3] = 32'h0000_0000;
    cfg_gap    = 16'd4;
    cfg_lo     = '0;
    cfg_hi     = '1;
    program_regs();
    t0 = {1'b0, 31'($urandom), $urandom};

    send_event(make_event(OP_TELEGRAM, '0, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b1, 1'b0));
    send_event(make_event(OP_TICK, '0, '0, '0, 1'b0, 1'b0, 1'b0));
    send_event(make_event(OP_SYNC, t0, '0, '0, 1'b0, 1'b0, 1'b0));
    send_event(make_event(OP_SYNC, t0 - 1, '0, '0, 1'b0, 1'b0, 1'b0));
    send_event(make_event(OP_SYNC, t0, '0, '0, 1'b0, 1'b0, 1'b0));
    send_event(make_event(OP_SYNC, t0 + 64'hFFFF_FFF0, '0, '0, 1'b0, 1'b0, 1'b0));
    send_event(make_event(OP_TELEGRAM, '0, 32'h1234_5678, 8'h00, 1'b0, 1'b1, 1'b1));
    send_event(make_event(OP_TELEGRAM, '0, 32'h1234_5678, 8'h00, 1'b0, 1'b1, 1'b1));
    repeat (5) send_event(make_event(OP_TICK, '0, '0, '0, 1'b0, 1'b0, 1'b0));
    send_event(make_event(OP_TELEGRAM, '0, 32'h1234_5678, 8'h00, 1'b0, 1'b1, 1'b0));
    send_event(make_event(OP_SYNC, t0 + 64'hFFFF_FFFE, '0, '0, 1'b0, 1'b0, 1'b0));
    send_event(make_event(OP_TELEGRAM, '0, 32'h1234_5678, 8'h00, 1'b0, 1'b1, 1'b1));
    send_event(make_event(OP_TELEGRAM, '0, 32'h1234_5678, 8'h00, 1'b0, 1'b1, 1'b1));
    repeat (2) send_event(make_event(OP_TICK, '0, '0, '0, 1'b0, 1'b0, 1'b0));
    send_event(make_event(OP_NONE, {$urandom, $urandom}, $urandom, 8'hA5, 1'b1, 1'b1, 1'b1));
    send_event(make_event(OP_TELEGRAM, '0, 32'hFFFF_FFFF, 8'h7F, 1'b1, 1'b1, 1'b1));
    send_event(make_event(OP_TELEGRAM, '0, 32'h0000_0000, 8'h01, 1'b0, 1'b0, 1'b0));
    send_event(make_event(OP_TELEGRAM, '0, 32'hABCD_EF01, 8'h02, 1'b0, 1'b1, 1'b1));
    send_event(make_event(OP_TELEGRAM, '0, 32'h0000_0000, 8'h80, 1'b0, 1'b1, 1'b1));
    send_event(make_event(OP_SYNC, '1, '0, '0, 1'b0, 1'b0, 1'b0));

    for (int phase = 0; phase < PHASES; phase++) begin
      idle_on = (phase < PHASES - 1);
      quiesce();
      choose_settings(phase);
      program_regs();
      for (int k = 0; k < PHASE_BEATS; k++) send_event(next_event());
    end
    quiesce();

    $display("Covered %0d event beats (%0d telegrams) under %0d register settings;",
             beats_sent, telegrams_sent, settings_used);
    $display("%0d results checked, %0d telegrams passed the filter.",
             results_seen, passed_count);
    if (fail_count == 0 && pending == 0)
      $display("[sensor_telegram_duplicate_filter_top] OK");
    else
      $display("[sensor_telegram_duplicate_filter_top] ERROR");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/stdf_pkg.sv
sv/stdf_ctrl.sv
sv/stdf_dp.sv
sv/sensor_telegram_duplicate_filter_top.sv
verif/telegram_filter_checker.sv
verif/testbench.sv
